[rtl/core/mpq_pkg.sv]
package mpq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 5;

    typedef enum logic {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic        [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

[rtl/core/min_priority_fifo_queue.sv]
// Min-first priority queue of DEPTH entries with first-in first-out order among
// equal priorities. Every input beat (enqueue or dequeue) gives exactly one result
// beat, held in the result register, and a new beat is taken in every cycle in
// which the result register is free or being drained, so the queue sustains one
// operation per clock. The entries sit sorted in a row of cells; on an enqueue each
// cell compares its own priority with the new one and either keeps its entry, takes
// the new one, or takes its left neighbor's, and on a dequeue every cell takes its
// right neighbor's entry while the first cell's entry is returned.
module min_priority_fifo_queue #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // in_data[31:0], in_priority[39:32]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_data[31:0], out_priority[39:32], occupancy[44:40]
    output logic [1:0]  m_tuser    // status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    mpq_pkg::status_t    status_reg;
    mpq_pkg::status_t    status_next;
    mpq_pkg::entry_t     result_reg;
    mpq_pkg::entry_t     result_next;
    logic [mpq_pkg::OCC_W-1:0] occ_reg;
    logic [mpq_pkg::OCC_W-1:0] occ_next;

    logic                in_beat;
    logic                full;
    logic                empty;
    mpq_pkg::mode_t      mode;
    mpq_pkg::entry_t     new_entry;
    mpq_pkg::cell_ctrl_t ctrl;
    mpq_pkg::entry_t     cell_entry [DEPTH];
    logic                cell_gt    [DEPTH];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign mode      = mpq_pkg::mode_t'(s_tuser);
    assign new_entry = '{data: s_tdata[31:0], prio: s_tdata[39:32]};
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctrl.enq = in_beat && (mode == mpq_pkg::MODE_ENQ) && !full;
    assign ctrl.deq = in_beat && (mode == mpq_pkg::MODE_DEQ) && !empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        mpq_pkg::entry_t left_entry;
        mpq_pkg::entry_t right_entry;
        logic            left_gt;

        if (i == 0) begin : g_first
            assign left_entry = new_entry;
            assign left_gt    = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        mpq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .occupied    (IDX < count_reg),
            .left_gt     (left_gt),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb begin
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        result_next   = result_reg;
        occ_next      = occ_reg;
        if (in_beat) begin
            m_tvalid_next = 1'b1;
            result_next   = '0;
            if (mode == mpq_pkg::MODE_ENQ) begin
                if (full) begin
                    status_next = mpq_pkg::ST_FULL;
                end else begin
                    status_next = mpq_pkg::ST_ENQ;
                    count_next  = count_reg + CW'(1);
                end
            end else begin
                if (empty) begin
                    status_next = mpq_pkg::ST_EMPTY;
                end else begin
                    status_next = mpq_pkg::ST_DEQ;
                    result_next = cell_entry[0];
                    count_next  = count_reg - CW'(1);
                end
            end
            occ_next = mpq_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        status_reg <= status_next;
        result_reg <= result_next;
        occ_reg    <= occ_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, occ_reg, result_reg.prio, result_reg.data};

endmodule

[rtl/core/mpq_cell.sv]
module mpq_cell (
    input  logic                aclk,
    input  mpq_pkg::cell_ctrl_t ctrl,
    input  mpq_pkg::entry_t     new_entry,
    input  mpq_pkg::entry_t     left_entry,
    input  mpq_pkg::entry_t     right_entry,
    input  logic                occupied,
    input  logic                left_gt,
    output mpq_pkg::entry_t     entry,
    output logic                gt
);

    mpq_pkg::entry_t entry_reg;
    mpq_pkg::entry_t entry_next;

    // A held entry that is strictly worse than the new one moves one cell right.
    assign gt    = occupied && (entry_reg.prio > new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.enq) begin
            if (left_gt) begin
                entry_next = left_entry;
            end else if (gt || !occupied) begin
                entry_next = new_entry;
            end
        end else if (ctrl.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/core/mpq_checker.sv]
module mpq_checker #(
    parameter int DEPTH = 16
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Every accepted enqueue reports either a stored entry or a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == mpq_pkg::MODE_ENQ) |=>
            m_tvalid && (m_tuser == mpq_pkg::ST_ENQ || m_tuser == mpq_pkg::ST_FULL))
        else $error("enqueue beat did not give an enqueue or full result");

    // An empty result carries no entry and reports an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mpq_pkg::ST_EMPTY) |-> (m_tdata[44:0] == '0))
        else $error("empty result with nonzero payload or occupancy");

    // A full result reports the queue at its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == mpq_pkg::ST_FULL) |->
            (m_tdata[44:40] == 5'(DEPTH)) && (m_tdata[39:0] == '0))
        else $error("full result with wrong occupancy or payload");

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

endmodule

bind min_priority_fifo_queue mpq_checker #(.DEPTH(DEPTH)) u_mpq_checker (.*);
